// ----- sv/bbc_pkg.sv -----
`default_nettype none

package bbc_pkg;

    localparam int SLOTS    = 32;
    localparam int TAG_BITS = 32;
    localparam int REF_BITS = 8;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LEN_W  = $clog2(SLOTS + 1);

    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    // request codes
    localparam logic [1:0] REQ_GET     = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_RECLAIM = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_NO_FREE = 3'd2;
    localparam logic [2:0] ST_BAD_REL = 3'd3;
    localparam logic [2:0] ST_REF_OVF = 3'd4;

    // free list cell operations
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_PUSH
    } t_cell_op;

    typedef struct packed {
        t_cell_op          op;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] slot;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- sv/bbc_cell.sv -----
`default_nettype none

module bbc_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [bbc_pkg::SLOT_W-1:0] i_pos,
    input  wire logic [bbc_pkg::SLOT_W-1:0] i_rst_slot,
    input  wire logic [bbc_pkg::SLOT_W-1:0] i_prev,
    input  wire logic [bbc_pkg::SLOT_W-1:0] i_next,
    input  wire bbc_pkg::t_cell_ctl         i_ctl,
    output logic      [bbc_pkg::SLOT_W-1:0] o_slot
);

    logic [bbc_pkg::SLOT_W-1:0] r_slot;

    // one free list entry: shifts toward the head on removal, toward the tail on push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= i_rst_slot;
        end else begin
            unique case (i_ctl.op)
                bbc_pkg::CELL_REMOVE: begin
                    if (i_pos >= i_ctl.pos) r_slot <= i_next;
                end
                bbc_pkg::CELL_PUSH: begin
                    r_slot <= (i_pos == '0) ? i_ctl.slot : i_prev;
                end
                default: ;
            endcase
        end
    end

    assign o_slot = r_slot;

endmodule

`default_nettype wire

// ----- sv/block_buffer_cache_lru_top.sv -----
//  channel  | direction | handshake          | payload
//  request  | in        | i_valid / o_stall  | i_req_type, i_block_number, i_release_slot,
//           |           |                    | i_reclaim_count
//  result   | out       | o_valid / i_stall  | o_status, o_slot_index, o_needs_page,
//           |           |                    | o_needs_read, o_freed_count
//
//  get and release: after the transfer come the tag match (S_LOOK) and the update (S_APPLY),
//  and the update loads the result; the next transfer waits until the block is back in S_IDLE.
//  reclaim walks one free list entry per cycle from the tail, ending when the head is passed
//  or i_reclaim_count slots are freed; the walk over the free list cells sets its length.
//  one request is in work at a time; a new one is taken while a result waits.
//  a stalled result holds the update step until the output register frees.
//  reset is synchronous: all slots invalid and unreferenced, free list full.
`default_nettype none

module block_buffer_cache_lru_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_block_number,
    input  wire logic [4:0]  i_release_slot,
    input  wire logic [5:0]  i_reclaim_count,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [4:0]       o_slot_index,
    output logic             o_needs_page,
    output logic             o_needs_read,
    output logic [5:0]       o_freed_count
);

    localparam int SW = bbc_pkg::SLOT_W;
    localparam int LW = bbc_pkg::LEN_W;
    localparam int RB = bbc_pkg::REF_BITS;
    localparam int TB = bbc_pkg::TAG_BITS;
    localparam int NS = bbc_pkg::SLOTS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_APPLY,
        S_RECL
    } t_state;

    t_state r_state;

    // latched request
    logic [1:0]    r_req;
    logic [TB-1:0] r_tag;
    logic [4:0]    r_rel;
    logic [5:0]    r_count;

    // tag match result
    logic          r_hit;
    logic [SW-1:0] r_hit_slot;

    // reclaim walk
    logic [LW-1:0] r_idx;
    logic [5:0]    r_freed;

    // slot state
    logic [TB-1:0] r_tag_mem [NS];
    logic [NS-1:0] r_tag_valid;
    logic [RB-1:0] r_ref [NS];
    logic [NS-1:0] r_page;
    logic [LW-1:0] r_len;

    // output register
    logic       r_out_valid;
    logic [2:0] r_status;
    logic [4:0] r_slot_out;
    logic       r_np;
    logic       r_nr;
    logic [5:0] r_freed_out;

    // free list cells
    logic [SW-1:0]      w_cell [NS];
    logic [SW-1:0]      w_prev [NS];
    logic [SW-1:0]      w_next [NS];
    bbc_pkg::t_cell_ctl w_ctl;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_prev[k] = (k == 0) ? w_cell[k] : w_cell[(k == 0) ? 0 : k - 1];
            w_next[k] = (k == NS - 1) ? w_cell[k] : w_cell[(k == NS - 1) ? k : k + 1];
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_cell
        bbc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_pos      (SW'(g)),
            .i_rst_slot (SW'(NS - 1 - g)),
            .i_prev     (w_prev[g]),
            .i_next     (w_next[g]),
            .i_ctl      (w_ctl),
            .o_slot     (w_cell[g])
        );
    end

    // parallel tag compare, lowest slot wins
    logic          w_hit;
    logic [SW-1:0] w_hit_slot;
    always_comb begin
        w_hit      = 1'b0;
        w_hit_slot = '0;
        for (int k = 0; k < NS; k++) begin
            if (!w_hit && r_tag_valid[k] && r_tag_mem[k] == r_tag) begin
                w_hit      = 1'b1;
                w_hit_slot = SW'(k);
            end
        end
    end

    // position of the hit slot within the free list
    logic          w_in_list;
    logic [SW-1:0] w_list_pos;
    always_comb begin
        w_in_list  = 1'b0;
        w_list_pos = '0;
        for (int k = 0; k < NS; k++) begin
            if (!w_in_list && k < int'(r_len) && w_cell[k] == r_hit_slot) begin
                w_in_list  = 1'b1;
                w_list_pos = SW'(k);
            end
        end
    end

    wire w_out_free = !r_out_valid || !i_stall;

    logic [SW-1:0] w_tail_slot;
    logic [SW-1:0] w_walk_slot;
    logic [SW-1:0] w_rel_slot;
    assign w_tail_slot = w_cell[SW'(r_len - LW'(1))];
    assign w_walk_slot = w_cell[SW'(r_idx - LW'(1))];
    assign w_rel_slot  = SW'(r_rel);

    // update decisions
    logic          a_done;
    logic [2:0]    a_status;
    logic [4:0]    a_slot;
    logic          a_np;
    logic          a_nr;
    logic [SW-1:0] w_idx;
    logic          w_ref_we;
    logic [RB-1:0] w_ref_val;
    logic          w_page_we;
    logic          w_page_val;
    logic          w_valid_we;
    logic          w_valid_val;
    logic          w_tag_we;
    logic [LW-1:0] n_len;
    logic          w_strip;
    logic          w_walk_end;
    logic          w_load;

    assign w_walk_end = (r_idx == '0) || (r_freed >= r_count);
    assign w_strip    = (r_state == S_RECL) && !w_walk_end && r_page[w_walk_slot];

    // a result enters the output register
    assign w_load = a_done || ((r_state == S_RECL) && w_walk_end && w_out_free);

    always_comb begin
        a_done      = 1'b0;
        a_status    = bbc_pkg::ST_OK;
        a_slot      = '0;
        a_np        = 1'b0;
        a_nr        = 1'b0;
        w_idx       = r_hit_slot;
        w_ref_we    = 1'b0;
        w_ref_val   = '0;
        w_page_we   = 1'b0;
        w_page_val  = 1'b0;
        w_valid_we  = 1'b0;
        w_valid_val = 1'b0;
        w_tag_we    = 1'b0;
        n_len       = r_len;
        w_ctl.op    = bbc_pkg::CELL_HOLD;
        w_ctl.pos   = '0;
        w_ctl.slot  = '0;
        if (r_state == S_APPLY && w_out_free) begin
            a_done = 1'b1;
            unique case (r_req)
                bbc_pkg::REQ_GET: begin
                    if (r_hit) begin
                        a_slot = 5'(r_hit_slot);
                        if (r_ref[r_hit_slot] >= bbc_pkg::REF_MAX) begin
                            a_status = bbc_pkg::ST_REF_OVF;
                        end else begin
                            w_ref_we  = 1'b1;
                            w_ref_val = r_ref[r_hit_slot] + RB'(1);
                            if (r_ref[r_hit_slot] == '0 && w_in_list) begin
                                w_ctl.op  = bbc_pkg::CELL_REMOVE;
                                w_ctl.pos = w_list_pos;
                                n_len     = r_len - LW'(1);
                            end
                        end
                    end else if (r_len == '0) begin
                        a_status = bbc_pkg::ST_NO_FREE;
                    end else begin
                        w_idx       = w_tail_slot;
                        a_slot      = 5'(w_tail_slot);
                        a_status    = bbc_pkg::ST_MISS;
                        a_np        = !r_page[w_tail_slot];
                        a_nr        = 1'b1;
                        n_len       = r_len - LW'(1);
                        w_page_we   = 1'b1;
                        w_page_val  = 1'b1;
                        w_valid_we  = 1'b1;
                        w_valid_val = 1'b1;
                        w_tag_we    = 1'b1;
                        w_ref_we    = 1'b1;
                        w_ref_val   = RB'(1);
                    end
                end
                bbc_pkg::REQ_RELEASE: begin
                    a_slot = r_rel;
                    w_idx  = w_rel_slot;
                    if (int'(r_rel) >= NS || r_ref[w_rel_slot] == '0) begin
                        a_status = bbc_pkg::ST_BAD_REL;
                    end else begin
                        w_ref_we  = 1'b1;
                        w_ref_val = r_ref[w_rel_slot] - RB'(1);
                        if (r_ref[w_rel_slot] == RB'(1) && int'(r_len) < NS) begin
                            w_ctl.op   = bbc_pkg::CELL_PUSH;
                            w_ctl.slot = w_rel_slot;
                            n_len      = r_len + LW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end else if (w_strip) begin
            w_idx       = w_walk_slot;
            w_page_we   = 1'b1;
            w_page_val  = 1'b0;
            w_valid_we  = 1'b1;
            w_valid_val = 1'b0;
        end
    end

    // slot state and free list length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_valid <= '0;
            r_page      <= '0;
            r_len       <= LW'(NS);
            for (int k = 0; k < NS; k++) r_ref[k] <= '0;
        end else begin
            r_len <= n_len;
            if (w_ref_we)   r_ref[w_idx]       <= w_ref_val;
            if (w_page_we)  r_page[w_idx]      <= w_page_val;
            if (w_valid_we) r_tag_valid[w_idx] <= w_valid_val;
        end
    end

    // tag store, no reset
    always_ff @(posedge i_clk) begin
        if (w_tag_we) r_tag_mem[w_idx] <= r_tag;
    end

    // control sequence and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req   <= i_req_type;
                        r_tag   <= i_block_number[TB-1:0];
                        r_rel   <= i_release_slot;
                        r_count <= i_reclaim_count;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_hit      <= w_hit;
                    r_hit_slot <= w_hit_slot;
                    r_idx      <= r_len;
                    r_freed    <= '0;
                    r_state    <= (r_req == bbc_pkg::REQ_RECLAIM) ? S_RECL : S_APPLY;
                end
                S_APPLY: begin
                    if (a_done) begin
                        r_status    <= a_status;
                        r_slot_out  <= a_slot;
                        r_np        <= a_np;
                        r_nr        <= a_nr;
                        r_freed_out <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_RECL: begin
                    if (w_walk_end) begin
                        if (w_out_free) begin
                            r_status    <= bbc_pkg::ST_OK;
                            r_slot_out  <= '0;
                            r_np        <= 1'b0;
                            r_nr        <= 1'b0;
                            r_freed_out <= r_freed;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_idx <= r_idx - LW'(1);
                        if (w_strip) r_freed <= r_freed + 6'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_slot_index  = r_slot_out;
    assign o_needs_page  = r_np;
    assign o_needs_read  = r_nr;
    assign o_freed_count = r_freed_out;

endmodule

`default_nettype wire
